>>> design/msc_pkg.sv
// Shared constants, codes and types of the matrix structure classifier.
package msc_pkg;

  localparam int unsigned MAX_DIM     = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned DIM_W       = 5;
  localparam int unsigned ADDR_W      = 2 * IDX_W;
  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic diag;
    logic sym;
    logic low;
    logic up;
  } flags_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] n);
    return (n > MAX_DIM_V) ? MAX_DIM_V : n;
  endfunction

endpackage

>>> design/msc_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module msc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> design/matrix_structure_classifier_top.sv
// Matrix structure classifier: element store, bounds-checked access, structure walk.
//
//   channel  dir  fields
//   s_axis   in   tuser: op[1:0]; tdata: row[3:0], col[7:4], value[39:8]
//   m_axis   out  tuser: in_range; tdata: read_value[31:0], is_diagonal[32],
//                 is_symmetric[33], is_lower[34], is_upper[35], is_triangular[36]
//   apb      in   row_count at 0x0, column_count at 0x4 (5 bits each)
//
// A write or unused op goes straight to finish, a read via the read state, a
// classify via the walk and tail state (to finish at once if rows or cols is 0);
// the walk reads one element and its transpose per cycle from the dual-read RAM.
// Reset clears the state machine, the count registers and the output register;
// the element RAM is not cleared. A stalled result waits in the output register
// while the next item is accepted; that item holds until the register frees.
module matrix_structure_classifier_top
  import msc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // row, col, value
  input  logic [1:0]             s_axis_tuser,   // op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // read_value, diag, sym, lower, upper, tri
  output logic                   m_axis_tuser,   // in_range
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_TAIL,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [DIM_W-1:0]  row_cnt_q, col_cnt_q;
  logic [IDX_W-1:0]  i_q, j_q, pi_q, pj_q;
  logic              eval_q;
  flags_t            flags_q;
  logic [ELEM_W-1:0] res_value_q;
  logic              res_in_range_q;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic              out_user_q;

  logic [DIM_W-1:0]  rows, cols;
  logic [IDX_W-1:0]  in_row, in_col;
  logic [ELEM_W-1:0] in_value;
  op_e               in_op;
  logic              accept, in_ok, out_free, cfg_wr;
  logic              walk_last_col, walk_last;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [ELEM_W-1:0] rdata_a, rdata_b;
  logic              ram_we;

  assign rows     = clamp_dim(row_cnt_q);
  assign cols     = clamp_dim(col_cnt_q);
  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
  assign in_op    = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_ok         = ({1'b0, in_row} < rows) && ({1'b0, in_col} < cols);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign walk_last_col = ({1'b0, j_q} == cols - DIM_W'(1));
  assign walk_last     = walk_last_col && ({1'b0, i_q} == rows - DIM_W'(1));

  assign ram_we  = accept && (in_op == OP_WRITE) && in_ok;
  assign raddr_a = (state_q == ST_IDLE) ? {in_row, in_col} : {i_q, j_q};
  assign raddr_b = {j_q, i_q};

  msc_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   ({in_row, in_col}),
    .wdata_i   (in_value),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (reg_e'(paddr[2]) == REG_COLUMN_COUNT) ?
                  {{(PDATA_W-DIM_W){1'b0}}, col_cnt_q} :
                  {{(PDATA_W-DIM_W){1'b0}}, row_cnt_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_cnt_q      <= '0;
      col_cnt_q      <= '0;
      i_q            <= '0;
      j_q            <= '0;
      pi_q           <= '0;
      pj_q           <= '0;
      eval_q         <= 1'b0;
      flags_q        <= '0;
      res_value_q    <= '0;
      res_in_range_q <= 1'b0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
      out_user_q     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_e'(paddr[2]))
          REG_ROW_COUNT:    row_cnt_q <= pwdata[DIM_W-1:0];
          REG_COLUMN_COUNT: col_cnt_q <= pwdata[DIM_W-1:0];
          default:          ;
        endcase
      end

      if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      eval_q <= (state_q == ST_WALK);
      pi_q   <= i_q;
      pj_q   <= j_q;

      if (eval_q) begin
        if ((pi_q != pj_q) && (rdata_a != '0)) flags_q.diag <= 1'b0;
        if ((pi_q < pj_q) && (rdata_a != '0))  flags_q.low  <= 1'b0;
        if ((pi_q > pj_q) && (rdata_a != '0))  flags_q.up   <= 1'b0;
        if (rdata_a != rdata_b)                flags_q.sym  <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_value_q <= '0;
            unique case (in_op)
              OP_WRITE: begin
                res_in_range_q <= in_ok;
                flags_q        <= '0;
                state_q        <= ST_FIN;
              end
              OP_READ: begin
                res_in_range_q <= in_ok;
                flags_q        <= '0;
                state_q        <= ST_READ;
              end
              OP_CLASSIFY: begin
                res_in_range_q <= 1'b0;
                flags_q        <= {(rows == cols), (rows == cols), 1'b1, 1'b1};
                i_q            <= '0;
                j_q            <= '0;
                state_q        <= ((rows == '0) || (cols == '0)) ? ST_FIN : ST_WALK;
              end
              default: begin
                res_in_range_q <= 1'b0;
                flags_q        <= '0;
                state_q        <= ST_FIN;
              end
            endcase
          end
        end
        ST_READ: begin
          res_value_q <= res_in_range_q ? rdata_a : '0;
          state_q     <= ST_FIN;
        end
        ST_WALK: begin
          if (walk_last) begin
            state_q <= ST_TAIL;
          end else if (walk_last_col) begin
            j_q <= '0;
            i_q <= i_q + IDX_W'(1);
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_TAIL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_user_q  <= res_in_range_q;
            out_data_q  <= {{(OUT_DATA_W-ELEM_W-5){1'b0}},
                            flags_q.low || flags_q.up,
                            flags_q.up, flags_q.low, flags_q.sym, flags_q.diag,
                            res_value_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
